// ----- rtl/core/eqs_pkg.sv -----
`default_nettype none
package eqs_pkg;

  localparam int AngleBits   = 24;
  localparam int CordicIters = 18;
  localparam int CordicW     = 34;
  localparam int IdxW        = 12;
  localparam int ColStepW    = 25;
  localparam int RowStepW    = 24;
  localparam int CoordW      = 16;
  localparam int ProdW       = CordicW * 2;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_COL_STEP = 3'd0,
    REG_ROW_STEP = 3'd1,
    REG_AXIS_X   = 3'd2,
    REG_AXIS_Y   = 3'd3,
    REG_AXIS_Z   = 3'd4,
    REG_CULL     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sphere_x;
    logic signed [15:0] sphere_y;
    logic signed [15:0] sphere_z;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic               visible;
  } out_beat_t;

  typedef struct packed {
    logic [ColStepW-1:0] col_step;
    logic [RowStepW-1:0] row_step;
    logic signed [15:0]  axis_x;
    logic signed [15:0]  axis_y;
    logic signed [15:0]  axis_z;
    logic signed [15:0]  cull;
  } cfg_t;

  // cordic element: rotation state for one angle
  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [CordicW-1:0] z;
    logic                      neg;
  } cordic_t;

  function automatic logic signed [CordicW-1:0] atan_entry(input logic [4:0] i);
    logic signed [CordicW-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10680862;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up at bit s, clamp to +-2^14
  function automatic logic signed [CoordW-1:0] rnd_clamp(input logic signed [ProdW-1:0] v,
                                                          input logic [5:0] s);
    logic signed [ProdW-1:0] r;
    r = (v + (ProdW'(1) <<< (s - 6'd1))) >>> s;
    if (r > ProdW'(16384)) r = ProdW'(16384);
    if (r < -ProdW'(16384)) r = -ProdW'(16384);
    return r[CoordW-1:0];
  endfunction

  function automatic cordic_t cordic_init(input logic [AngleBits-1:0] p);
    cordic_t c;
    logic [31:0] ph;
    ph = {p, {(32-AngleBits){1'b0}}};
    c.neg = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (c.neg) ph = ph + 32'h8000_0000;
    c.x = CordicGain;
    c.y = '0;
    c.z = CordicW'(signed'(ph));
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/eqs_cordic_step.sv -----
`default_nettype none
module eqs_cordic_step
  import eqs_pkg::*;
(
  input  wire logic [4:0] shift,
  input  cordic_t         a,
  output cordic_t         b
);
  logic signed [CordicW-1:0] dx, dy, at;
  always_comb begin
    dx = a.y >>> shift;
    dy = a.x >>> shift;
    at = atan_entry(shift);
    b.neg = a.neg;
    if (!a.z[CordicW-1]) begin
      b.x = a.x - dx;
      b.y = a.y + dy;
      b.z = a.z - at;
    end else begin
      b.x = a.x + dx;
      b.y = a.y - dy;
      b.z = a.z + at;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/eqs_cfg_regs.sv -----
`default_nettype none
module eqs_cfg_regs
  import eqs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata,
  output cfg_t             cfg
);
  cfg_t cfg_r, cfg_nxt;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_COL_STEP: cfg_nxt.col_step = cfg_wdata;
        REG_ROW_STEP: cfg_nxt.row_step = cfg_wdata[RowStepW-1:0];
        REG_AXIS_X:   cfg_nxt.axis_x = cfg_wdata[15:0];
        REG_AXIS_Y:   cfg_nxt.axis_y = cfg_wdata[15:0];
        REG_AXIS_Z:   cfg_nxt.axis_z = cfg_wdata[15:0];
        REG_CULL:     cfg_nxt.cull = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_step <= 25'd4096;
      cfg_r.row_step <= 24'd4096;
      cfg_r.axis_x   <= 16'sd0;
      cfg_r.axis_y   <= 16'sd0;
      cfg_r.axis_z   <= 16'sd16384;
      cfg_r.cull     <= -16'sd1638;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
  assign cfg = cfg_r;
endmodule
`default_nettype wire

// ----- rtl/core/equirect_pixel_to_sphere_cull.sv -----
`default_nettype none
// Equirectangular pixel to unit-sphere point with view culling.
// Input channel in_valid/in_stall/in_data carries one pixel per beat:
// column, row and the three colour bytes. Output channel out_valid/
// out_stall/out_data returns one beat per pixel: sphere x, y, z in Q2.14,
// the colour bytes unchanged and the visible flag.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, only while
// no beat is in flight: a rule for the user that the block does not enforce.
// Stages from accepted input beat to out_valid, in order:
// 1 phase multiply, 18 cordic stages for both angles side by side,
// 1 sign fix, 1 product, 1 rounding, 1 axis multiply,
// 1 sum, compare and output register.
// Throughput: one beat per cycle; the whole pipe advances together and
// holds every stage while out_valid is high and out_stall is high.
// in_stall is high only in that case, so nothing is dropped or repeated.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// register defaults: both phase steps 4096, view axis +z, cull -1638.
module equirect_pixel_to_sphere_cull
  import eqs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_beat_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_wdata
);
  localparam int NStg = CordicIters + 6;

  cfg_t cfg;
  eqs_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .cfg
  );

  logic adv;
  logic [NStg-1:0] v_r;
  assign adv = !(v_r[NStg-1] && out_stall);
  assign in_stall = !adv;

  // stage 0: phases
  logic [AngleBits-1:0] plon_r, plat_r;
  logic [23:0] rgb_r [NStg];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NStg-2:0], in_valid};
  end

  logic [ColStepW+IdxW-1:0] lon_full;
  logic [RowStepW+IdxW-1:0] lat_full;
  assign lon_full = in_data.column * cfg.col_step;
  assign lat_full = in_data.row * cfg.row_step;

  always_ff @(posedge clk) begin
    if (adv) begin
      plon_r <= lon_full[AngleBits-1:0];
      plat_r <= lat_full[AngleBits-1:0];
      rgb_r[0] <= {in_data.red, in_data.green, in_data.blue};
      for (int k = 1; k < NStg; k++) rgb_r[k] <= rgb_r[k-1];
    end
  end

  // cordic stages 1..18
  cordic_t lon_r [CordicIters+1];
  cordic_t lat_r [CordicIters+1];
  cordic_t lon_n [CordicIters];
  cordic_t lat_n [CordicIters];
  always_comb begin
    lon_r[0] = cordic_init(plon_r);
    lat_r[0] = cordic_init(plat_r);
  end

  for (genvar g = 0; g < CordicIters; g++) begin : g_cordic
    eqs_cordic_step u_lon (.shift(5'(g)), .a(lon_r[g]), .b(lon_n[g]));
    eqs_cordic_step u_lat (.shift(5'(g)), .a(lat_r[g]), .b(lat_n[g]));
    always_ff @(posedge clk) begin
      if (adv) begin
        lon_r[g+1] <= lon_n[g];
        lat_r[g+1] <= lat_n[g];
      end
    end
  end

  logic signed [CordicW-1:0] clon, slon, clat, slat;
  always_comb begin
    cordic_t a, b;
    a = lon_r[CordicIters];
    b = lat_r[CordicIters];
    clon = a.neg ? -a.x : a.x;
    slon = a.neg ? -a.y : a.y;
    clat = b.neg ? -b.x : b.x;
    slat = b.neg ? -b.y : b.y;
  end

  // products, split into partial stages
  logic signed [CordicW-1:0] slon_r, clon_r, slat_r, clat_r;
  logic signed [ProdW-1:0] px_r, pz_r;
  logic signed [CoordW-1:0] ny_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      slon_r <= slon; clon_r <= clon; slat_r <= slat; clat_r <= clat;
      px_r <= slon_r * slat_r;
      pz_r <= clon_r * slat_r;
      ny_r <= rnd_clamp(-ProdW'(clat_r), 6'd16);
    end
  end

  logic signed [CoordW-1:0] sx_r, sy_r, sz_r, sx2_r, sy2_r, sz2_r;
  logic signed [31:0] dx_r, dy_r, dz_r;
  logic vis_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= rnd_clamp(px_r, 6'd46);
      sz_r <= rnd_clamp(pz_r, 6'd46);
      sy_r <= ny_r;
      dx_r <= sx_r * cfg.axis_x;
      dy_r <= sy_r * cfg.axis_y;
      dz_r <= sz_r * cfg.axis_z;
      sx2_r <= sx_r; sy2_r <= sy_r; sz2_r <= sz_r;
      vis_r <= (34'(dx_r) + 34'(dy_r) + 34'(dz_r))
               <= (34'(cfg.cull) <<< 14);
    end
  end

  logic signed [CoordW-1:0] ox_r, oy_r, oz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= sx2_r; oy_r <= sy2_r; oz_r <= sz2_r;
    end
  end

  always_comb begin
    out_valid = v_r[NStg-1];
    out_data.sphere_x = ox_r;
    out_data.sphere_y = oy_r;
    out_data.sphere_z = oz_r;
    out_data.out_red = rgb_r[NStg-1][23:16];
    out_data.out_green = rgb_r[NStg-1][15:8];
    out_data.out_blue = rgb_r[NStg-1][7:0];
    out_data.visible = vis_r;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without back pressure");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sphere_y <= 16'sd16384 && out_data.sphere_y >= -16'sd16384))
    else $error("sphere y out of range");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import eqs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [24:0] cfg_wdata = '0;

  equirect_pixel_to_sphere_cull i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int PipeDepth = 25;
  localparam int WatchdogLimit = 20000;

  // local copy of the registers
  logic [24:0] col_step_q;
  logic [23:0] row_step_q;
  logic signed [15:0] axis_x_q, axis_y_q, axis_z_q, cull_q;

  out_beat_t pending_points[$];
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 0;

  const longint AtanTab[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void rotate_phase(logic [31:0] ph, output longint c, output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (flip) ph = ph + 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'(signed'(ph));
    for (int i = 0; i < 18; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint round_to_q14(longint v, int s);
    longint r;
    r = (v + (longint'(1) << (s - 1))) >>> s;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic logic [31:0] angle_of(logic [11:0] idx, logic [24:0] step);
    logic [63:0] p;
    p = 64'(idx) * 64'(step);
    return {p[23:0], 8'h00};
  endfunction

  function automatic out_beat_t project_pixel(in_beat_t px);
    out_beat_t r;
    longint clon, slon, clat, slat, sx, sy, sz, dot;
    // 12-bit fields never exceed 4095
    rotate_phase(angle_of(px.column, col_step_q), clon, slon);
    rotate_phase(angle_of(px.row, 25'(row_step_q)), clat, slat);
    sx = round_to_q14(slon * slat, 46);
    sy = round_to_q14(-clat, 16);
    sz = round_to_q14(clon * slat, 46);
    dot = sx * axis_x_q + sy * axis_y_q + sz * axis_z_q;
    r.sphere_x = 16'(sx);
    r.sphere_y = 16'(sy);
    r.sphere_z = 16'(sz);
    r.out_red = px.red;
    r.out_green = px.green;
    r.out_blue = px.blue;
    r.visible = (dot <= longint'(cull_q) * 16384);
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [24:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COL_STEP: col_step_q = val;
      REG_ROW_STEP: row_step_q = val[23:0];
      REG_AXIS_X: axis_x_q = val[15:0];
      REG_AXIS_Y: axis_y_q = val[15:0];
      REG_AXIS_Z: axis_z_q = val[15:0];
      REG_CULL: cull_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_points.size() != 0 && !timed_out) @(posedge clk);
    repeat (PipeDepth + 5) @(posedge clk);
  endtask

  // offers one beat and holds it until taken
  task automatic send_pixel(in_beat_t px);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall && !timed_out);
    pending_points.push_back(project_pixel(px));
    beats_in++;
    @(negedge clk);
  endtask

  function automatic in_beat_t random_pixel();
    in_beat_t px;
    logic [7:0] g;
    px.column = $urandom;
    px.row = $urandom;
    px.red = $urandom;
    px.green = $urandom;
    px.blue = $urandom;
    if ($urandom_range(9) == 0) begin
      g = $urandom;
      px.red = g; px.green = g; px.blue = g;
    end
    return px;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %p", out_data);
      end else begin
        out_beat_t e;
        e = pending_points.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired, %0d beats still expected", pending_points.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // column, row, rgb; expected point typed only for the origin under reset steps
  typedef struct {
    logic [11:0] c, r;
    logic [7:0] rd, gr, bl;
    bit known;
    out_beat_t want;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1,
      '{16'sd0, -16'sd16384, 16'sd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    '{12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1,
      '{16'sd0, -16'sd16384, 16'sd0, 8'd255, 8'd255, 8'd255, 1'b0}},
    '{12'd4095, 12'd0, 8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{12'd0, 12'd4095, 8'd1, 8'd2, 8'd3, 1'b0, '0},
    '{12'd4095, 12'd4095, 8'hAA, 8'h55, 8'hFF, 1'b0, '0},
    '{12'd1024, 12'd1024, 8'h55, 8'hAA, 8'h00, 1'b0, '0},
    '{12'd2048, 12'd2048, 8'd7, 8'd7, 8'd7, 1'b0, '0},
    '{12'd3072, 12'd3072, 8'h80, 8'h01, 8'hFE, 1'b0, '0},
    '{12'd512, 12'd1536, 8'd9, 8'd10, 8'd11, 1'b0, '0},
    '{12'd2560, 12'd2600, 8'd20, 8'd40, 8'd60, 1'b0, '0},
    '{12'hAAA, 12'h555, 8'h0F, 8'hF0, 8'h3C, 1'b0, '0},
    '{12'h555, 12'hAAA, 8'hC3, 8'h5A, 8'hA5, 1'b0, '0}
  };

  // several register settings, extremes included
  typedef struct {
    logic [24:0] cs;
    logic [23:0] rs;
    logic signed [15:0] ax, ay, az, th;
  } setting_t;

  setting_t settings[] = '{
    '{25'd4096, 24'd4096, 16'sd0, 16'sd0, 16'sd16384, -16'sd1638},
    '{25'd16777216, 24'd8388608, 16'sd16384, -16'sd16384, 16'sd0, 16'sd16384},
    '{25'd1, 24'd1, -16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384},
    '{25'd0, 24'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{25'h1FFFFFF, 24'hFFFFFF, 16'sd11585, 16'sd0, -16'sd11585, 16'sd100},
    '{25'd4096, 24'd2048, 16'sd0, 16'sd16384, 16'sd0, -16'sd1638}
  };

  initial begin
    in_beat_t px;
    col_step_q = 25'd4096;
    row_step_q = 24'd4096;
    axis_x_q = 0;
    axis_y_q = 0;
    axis_z_q = 16'sd16384;
    cull_q = -16'sd1638;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      px.column = directed[i].c;
      px.row = directed[i].r;
      px.red = directed[i].rd;
      px.green = directed[i].gr;
      px.blue = directed[i].bl;
      send_pixel(px);
      if (directed[i].known) pending_points[$] = directed[i].want;
    end
    drain();

    // an unknown index must leave every register alone
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_wdata <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      setting_t s;
      s = settings[ph % settings.size()];
      if (ph == 6) begin
        s.cs = $urandom_range(1, 25'h1000000);
        s.rs = $urandom_range(1, 24'h800000);
        s.ax = $urandom_range(0, 32768) - 16384;
        s.ay = $urandom_range(0, 32768) - 16384;
        s.az = $urandom_range(0, 32768) - 16384;
        s.th = $urandom_range(0, 32768) - 16384;
      end
      write_reg(REG_COL_STEP, s.cs);
      write_reg(REG_ROW_STEP, 25'(s.rs));
      write_reg(REG_AXIS_X, 25'(s.ax));
      write_reg(REG_AXIS_Y, 25'(s.ay));
      write_reg(REG_AXIS_Z, 25'(s.az));
      write_reg(REG_CULL, 25'(s.th));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (ph == 0) fork
        begin
          hold_recv = 1;
          repeat (80) @(posedge clk);
          hold_recv = 0;
        end
      join_none
      for (int k = 0; k < 105; k++) begin
        send_pixel(random_pixel());
        // sender waits for the pipe to empty once
        if (ph == 1 && k == 50) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (pending_points.size() != 0);
        end
      end
      drain();
    end

    $display("sent %0d pixels over 8 register settings and 4 idle/stall mixes, %0d checked",
             beats_in, beats_out);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, pending_points.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/eqs_pkg.sv
rtl/core/eqs_cordic_step.sv
rtl/core/eqs_cfg_regs.sv
rtl/core/equirect_pixel_to_sphere_cull.sv
tb/testbench.sv
